// ----- design/ring_deque_with_positional_insert_assert.svh -----
// Assertion macros used by the checker file.
`ifndef RING_DEQUE_WITH_POSITIONAL_INSERT_ASSERT_SVH
`define RING_DEQUE_WITH_POSITIONAL_INSERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdq assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdq assertion failed");

`endif

// ----- design/rdq_pkg.sv -----
`default_nettype none

package rdq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int MODE_W   = 3;
  localparam int DATA_W   = 32;
  localparam int SIZE_W   = 16;
  localparam int POS_W    = 16;
  localparam int STATUS_W = 3;
  localparam int FILL_W   = 5;

  // Operation codes
  localparam logic [MODE_W-1:0] M_INS_FIRST = 3'd0;
  localparam logic [MODE_W-1:0] M_INS_LAST  = 3'd1;
  localparam logic [MODE_W-1:0] M_INS_AT    = 3'd2;
  localparam logic [MODE_W-1:0] M_EXT_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] M_EXT_LAST  = 3'd4;
  localparam logic [MODE_W-1:0] M_EXT_AT    = 3'd5;
  localparam logic [MODE_W-1:0] M_PEEK_AT   = 3'd6;
  localparam logic [MODE_W-1:0] M_CLEAR     = 3'd7;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RANGE = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [SIZE_W-1:0] size;
  } slot_t;

endpackage

`default_nettype wire

// ----- design/rdq_in_if.sv -----
`default_nettype none

interface rdq_in_if;
  logic                          valid;
  logic                          ready;
  logic [rdq_pkg::MODE_W-1:0]    mode;
  logic [rdq_pkg::DATA_W-1:0]    entry_data;
  logic [rdq_pkg::SIZE_W-1:0]    entry_size;
  logic [rdq_pkg::POS_W-1:0]     position;

  modport source (output valid, mode, entry_data, entry_size, position, input ready);
  modport sink   (input valid, mode, entry_data, entry_size, position, output ready);
endinterface

`default_nettype wire

// ----- design/rdq_out_if.sv -----
`default_nettype none

interface rdq_out_if;
  logic                          valid;
  logic                          ready;
  logic [rdq_pkg::STATUS_W-1:0]  status;
  logic [rdq_pkg::DATA_W-1:0]    out_data;
  logic [rdq_pkg::SIZE_W-1:0]    out_size;
  logic [rdq_pkg::FILL_W-1:0]    fill_count;
  logic                          now_empty;
  logic                          now_full;

  modport source (output valid, status, out_data, out_size, fill_count, now_empty, now_full,
                  input ready);
  modport sink   (input valid, status, out_data, out_size, fill_count, now_empty, now_full,
                  output ready);
endinterface

`default_nettype wire

// ----- design/rdq_addr.sv -----
`default_nettype none

// Ring address unit: (base + off) mod DEPTH, both operands below DEPTH.
module rdq_addr #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire logic [$clog2(DEPTH)-1:0] base,
  input  wire logic [$clog2(DEPTH)-1:0] off,
  output logic      [$clog2(DEPTH)-1:0] sum
);
  import rdq_pkg::*;

  localparam int IW = $clog2(DEPTH);

  logic [IW:0] raw;

  always_comb begin
    raw = {1'b0, base} + {1'b0, off};
    // operands stay below DEPTH, so one subtract is enough
    if (raw >= (IW+1)'(DEPTH)) begin
      sum = IW'(raw - (IW+1)'(DEPTH));
    end else begin
      sum = IW'(raw);
    end
  end
endmodule

`default_nettype wire

// ----- design/rdq_store.sv -----
`default_nettype none

// Slot memory: one write port, one read port with registered read data.
module rdq_store #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire rdq_pkg::slot_t           wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output rdq_pkg::slot_t                rdata
);
  import rdq_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

// ----- design/ring_deque_with_positional_insert.sv -----
// Ring deque with positional insert and extract.
// in_ch carries one operation per item (mode, entry_data, entry_size,
// position); out_ch returns exactly one result item per operation with the
// status, the extracted or peeked entry and the fill level afterwards.
// Both channels use valid/ready; an item moves when both are high.
// Clear, errors and end inserts go from the check state straight to done;
// end extracts and peek pass through the grab state; positional inserts
// and extracts pass through the shift state, which moves the entries
// after the position. The slot memory's single write port moves one entry
// per cycle, with the ring address adder shared by every ring address
// and pointer update.
// One operation is in flight at a time: in_ch.ready is high only while
// the sequencer is idle, so no new item is taken until the last one is done.
// The result sits in an output register; the next item is accepted while
// it waits, and that item's result holds in the done state until out_ch
// frees the register. Reset (rst_n low, synchronous) empties the deque and
// drops any pending result; slot contents are not cleared and need not be.
`default_nettype none

module ring_deque_with_positional_insert #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rdq_in_if.sink     in_ch,
  rdq_out_if.source  out_ch
);
  import rdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_GRAB  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          state_r, state_nxt;

  // latched item
  logic [MODE_W-1:0]   mode_r;
  logic [DATA_W-1:0]   data_r;
  logic [SIZE_W-1:0]   size_r;
  logic [POS_W-1:0]    pos_r;

  // deque state
  logic [IW-1:0]       front_r, front_nxt;
  logic [IW-1:0]       back_r, back_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  // shift engine
  logic [IW-1:0]       dst_r, dst_nxt;
  logic [IW-1:0]       src_r, src_nxt;
  logic [IW-1:0]       lj_r, lj_nxt;
  logic [CW-1:0]       rem_r, rem_nxt;
  logic                rd_pend_r, rd_pend_nxt;

  // result being built
  logic [STATUS_W-1:0] status_r, status_nxt;
  slot_t               od_r, od_nxt;

  // output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] res_status_r;
  slot_t               res_slot_r;
  logic [FILL_W-1:0]   res_fill_r;
  logic                res_empty_r;
  logic                res_full_r;
  logic                res_load;

  // shared address unit and memory ports
  logic [IW-1:0]       au_base, au_off, au_sum;
  logic                mem_we, mem_re;
  logic [IW-1:0]       mem_waddr, mem_raddr;
  slot_t               mem_wdata, mem_rdata;

  // decode helpers
  logic                is_ins, is_full, pos_past, front_ins, append;

  rdq_addr #(.DEPTH(DEPTH)) u_addr (
    .base (au_base),
    .off  (au_off),
    .sum  (au_sum)
  );

  rdq_store #(.DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    is_ins    = mode_r inside {M_INS_FIRST, M_INS_LAST, M_INS_AT};
    is_full   = (count_r == CW'(DEPTH));
    pos_past  = (pos_r >= POS_W'(count_r));
    front_ins = (mode_r == M_INS_FIRST) ||
                ((mode_r == M_INS_AT) && (pos_r == '0) && (count_r != '0));
    append    = (mode_r == M_INS_LAST) || pos_past;
  end

  always_comb begin
    state_nxt   = state_r;
    front_nxt   = front_r;
    back_nxt    = back_r;
    count_nxt   = count_r;
    dst_nxt     = dst_r;
    src_nxt     = src_r;
    lj_nxt      = lj_r;
    rem_nxt     = rem_r;
    rd_pend_nxt = rd_pend_r;
    status_nxt  = status_r;
    od_nxt      = od_r;
    au_base     = front_r;
    au_off      = '0;
    mem_we      = 1'b0;
    mem_waddr   = dst_r;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = au_sum;
    res_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          status_nxt = ST_OK;
          od_nxt     = '0;
          state_nxt  = S_CHECK;
        end
      end

      S_CHECK: begin
        if (is_ins) begin
          if (size_r == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_DONE;
          end else if (is_full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (front_ins) begin
            // step front back one slot and drop the entry there
            au_base   = front_r;
            au_off    = IW'(DEPTH - 1);
            mem_we    = 1'b1;
            mem_waddr = au_sum;
            mem_wdata = '{data: data_r, size: size_r};
            front_nxt = au_sum;
            count_nxt = count_r + 1'b1;
            state_nxt = S_DONE;
          end else if (append) begin
            au_base   = back_r;
            au_off    = IW'(1);
            mem_we    = 1'b1;
            mem_waddr = back_r;
            mem_wdata = '{data: data_r, size: size_r};
            back_nxt  = au_sum;
            count_nxt = count_r + 1'b1;
            state_nxt = S_DONE;
          end else begin
            // open a hole at pos: move entries count-1 .. pos up one slot
            au_base     = front_r;
            au_off      = IW'(count_r);
            dst_nxt     = au_sum;
            lj_nxt      = IW'(count_r - 1'b1);
            rem_nxt     = count_r - CW'(pos_r);
            rd_pend_nxt = 1'b0;
            state_nxt   = S_SHIFT;
          end
        end else if (mode_r == M_CLEAR) begin
          front_nxt = '0;
          back_nxt  = '0;
          count_nxt = '0;
          state_nxt = S_DONE;
        end else if (count_r == '0) begin
          status_nxt = ST_EMPTY;
          state_nxt  = S_DONE;
        end else if (mode_r == M_EXT_FIRST) begin
          au_base   = front_r;
          au_off    = IW'(1);
          mem_re    = 1'b1;
          mem_raddr = front_r;
          front_nxt = au_sum;
          count_nxt = count_r - 1'b1;
          state_nxt = S_GRAB;
        end else if (mode_r == M_EXT_LAST) begin
          au_base   = back_r;
          au_off    = IW'(DEPTH - 1);
          mem_re    = 1'b1;
          mem_raddr = au_sum;
          back_nxt  = au_sum;
          count_nxt = count_r - 1'b1;
          state_nxt = S_GRAB;
        end else if (pos_past) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          // peek or extract at pos: read the entry first
          au_base   = front_r;
          au_off    = IW'(pos_r);
          mem_re    = 1'b1;
          mem_raddr = au_sum;
          dst_nxt   = au_sum;
          lj_nxt    = IW'(pos_r + 1'b1);
          rem_nxt   = count_r - CW'(pos_r) - 1'b1;
          state_nxt = S_GRAB;
        end
      end

      S_GRAB: begin
        od_nxt = mem_rdata;
        if (mode_r == M_EXT_AT) begin
          rd_pend_nxt = 1'b0;
          state_nxt   = S_SHIFT;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_SHIFT: begin
        // write the entry read last cycle into the slot it moves to
        if (rd_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = mem_rdata;
          dst_nxt   = src_r;
        end
        if (rem_r != '0) begin
          au_base     = front_r;
          au_off      = lj_r;
          mem_re      = 1'b1;
          mem_raddr   = au_sum;
          src_nxt     = au_sum;
          lj_nxt      = is_ins ? (lj_r - 1'b1) : (lj_r + 1'b1);
          rem_nxt     = rem_r - 1'b1;
          rd_pend_nxt = 1'b1;
        end else if (rd_pend_r) begin
          rd_pend_nxt = 1'b0;
        end else if (is_ins) begin
          // fill the hole and advance the back
          mem_we    = 1'b1;
          mem_waddr = dst_r;
          mem_wdata = '{data: data_r, size: size_r};
          au_base   = back_r;
          au_off    = IW'(1);
          back_nxt  = au_sum;
          count_nxt = count_r + 1'b1;
          state_nxt = S_DONE;
        end else begin
          au_base   = back_r;
          au_off    = IW'(DEPTH - 1);
          back_nxt  = au_sum;
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      front_r   <= '0;
      back_r    <= '0;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      front_r   <= front_nxt;
      back_r    <= back_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      data_r <= in_ch.entry_data;
      size_r <= in_ch.entry_size;
      pos_r  <= in_ch.position;
    end
    dst_r    <= dst_nxt;
    src_r    <= src_nxt;
    lj_r     <= lj_nxt;
    rem_r    <= rem_nxt;
    status_r <= status_nxt;
    od_r     <= od_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status_r <= status_r;
      res_slot_r   <= od_r;
      res_fill_r   <= FILL_W'(count_r);
      res_empty_r  <= (count_r == '0);
      res_full_r   <= is_full;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = res_status_r;
  assign out_ch.out_data   = res_slot_r.data;
  assign out_ch.out_size   = res_slot_r.size;
  assign out_ch.fill_count = res_fill_r;
  assign out_ch.now_empty  = res_empty_r;
  assign out_ch.now_full   = res_full_r;

endmodule

`default_nettype wire

// ----- design/rdq_checker.sv -----
`default_nettype none

`include "ring_deque_with_positional_insert_assert.svh"

module rdq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [rdq_pkg::STATUS_W-1:0]  status,
  input wire logic [rdq_pkg::DATA_W-1:0]    out_data,
  input wire logic [rdq_pkg::SIZE_W-1:0]    out_size,
  input wire logic [rdq_pkg::FILL_W-1:0]    fill_count,
  input wire logic                          now_empty,
  input wire logic                          now_full
);
  import rdq_pkg::*;

  // result holds while stalled
  `RDQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // one operation at a time: busy right after an accept
  `RDQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // rejected operations carry no entry
  `RDQ_ASSERT_NOW(a_err_no_entry, clk, rst_n, out_valid && (status != ST_OK),
                  (out_data == '0) && (out_size == '0))

  // empty and full flags agree with the fill level and the status
  `RDQ_ASSERT_NOW(a_flags, clk, rst_n, out_valid && (now_empty || (status == ST_FULL)),
                  (now_empty ? ((fill_count == '0) && !now_full) : now_full))

endmodule

bind ring_deque_with_positional_insert rdq_checker u_rdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .status     (out_ch.status),
  .out_data   (out_ch.out_data),
  .out_size   (out_ch.out_size),
  .fill_count (out_ch.fill_count),
  .now_empty  (out_ch.now_empty),
  .now_full   (out_ch.now_full)
);

`default_nettype wire

// ----- sim/ring_deque_with_positional_insert_tb.sv -----
`timescale 1ns / 100ps

import rdq_pkg::*;

// One result item as the deque reports it.
typedef struct packed {
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   data;
  logic [SIZE_W-1:0]   size;
  logic [FILL_W-1:0]   fill;
  logic                is_empty;
  logic                is_full;
} deque_result_t;

// Shadow deque: mirrors the ring contents, works out the result of every
// accepted operation and holds those results until the block returns them.
class deque_tracker;
  localparam int unsigned SLOTS = DEPTH_DEF;

  slot_t         ring[SLOTS];
  int unsigned   head;
  int unsigned   tail;
  int unsigned   count;
  deque_result_t pending_results[$];
  int unsigned   errors;

  function new();
    foreach (ring[i]) ring[i] = '0;
    head   = 0;
    tail   = 0;
    count  = 0;
    errors = 0;
  endfunction

  function int unsigned slot_of(int unsigned logical);
    return (head + logical) % SLOTS;
  endfunction

  function void note_op(logic [MODE_W-1:0] op, logic [DATA_W-1:0] word,
                        logic [SIZE_W-1:0] sz, logic [POS_W-1:0] at);
    deque_result_t r;
    int unsigned   idx;
    r = '0;
    r.status = ST_OK;
    if (op == M_INS_FIRST || op == M_INS_LAST || op == M_INS_AT) begin
      if (sz == '0) begin
        r.status = ST_ZERO;
      end else if (count >= SLOTS) begin
        r.status = ST_FULL;
      end else if (op == M_INS_FIRST || (op == M_INS_AT && at == '0 && count != 0)) begin
        head = (head + SLOTS - 1) % SLOTS;
        ring[head] = '{data: word, size: sz};
        count++;
      end else if (op == M_INS_LAST || at >= count) begin
        ring[tail] = '{data: word, size: sz};
        tail = (tail + 1) % SLOTS;
        count++;
      end else begin
        // open a hole at the position: move later entries up by one
        for (int unsigned k = count; k > at; k--) ring[slot_of(k)] = ring[slot_of(k - 1)];
        ring[slot_of(at)] = '{data: word, size: sz};
        tail = (tail + 1) % SLOTS;
        count++;
      end
    end else if (op == M_CLEAR) begin
      foreach (ring[i]) ring[i] = '0;
      head  = 0;
      tail  = 0;
      count = 0;
    end else if (count == 0) begin
      r.status = ST_EMPTY;
    end else if (op == M_EXT_FIRST) begin
      r.data = ring[head].data;
      r.size = ring[head].size;
      ring[head] = '0;
      head = (head + 1) % SLOTS;
      count--;
    end else if (op == M_EXT_LAST) begin
      tail = (tail + SLOTS - 1) % SLOTS;
      r.data = ring[tail].data;
      r.size = ring[tail].size;
      ring[tail] = '0;
      count--;
    end else if (at >= count) begin
      r.status = ST_RANGE;
    end else begin
      idx = slot_of(at);
      r.data = ring[idx].data;
      r.size = ring[idx].size;
      if (op == M_EXT_AT) begin
        // close the gap: move later entries down by one
        for (int unsigned k = at; k + 1 < count; k++) ring[slot_of(k)] = ring[slot_of(k + 1)];
        tail = (tail + SLOTS - 1) % SLOTS;
        ring[tail] = '0;
        count--;
      end
    end
    r.fill     = FILL_W'(count);
    r.is_empty = (count == 0);
    r.is_full  = (count >= SLOTS);
    pending_results.push_back(r);
  endfunction

  function bit field_ok(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void check_result(deque_result_t got);
    deque_result_t want;
    bit            ok;
    if (pending_results.size() == 0) begin
      $display("%0t: result with none expected, got %p", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    ok = 1'b1;
    ok &= field_ok("status", DATA_W'(want.status), DATA_W'(got.status));
    ok &= field_ok("out_data", want.data, got.data);
    ok &= field_ok("out_size", DATA_W'(want.size), DATA_W'(got.size));
    ok &= field_ok("fill_count", DATA_W'(want.fill), DATA_W'(got.fill));
    ok &= field_ok("now_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
    ok &= field_ok("now_full", DATA_W'(want.is_full), DATA_W'(got.is_full));
    if (!ok) errors++;
  endfunction
endclass

module ring_deque_with_positional_insert_tb;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1430;
  // last stretch of the run goes without any idling
  localparam int QUIET_ITEMS  = 200;
  // receiver hold-off long enough to back the block up into its input
  localparam int LONG_HOLD    = 300;
  // watchdog limit for the whole run, with room
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_POSITIONAL} phase_e;

  logic clk;
  logic rst_n;

  rdq_in_if  in_ch ();
  rdq_out_if out_ch ();

  ring_deque_with_positional_insert #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  deque_tracker tracker;

  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          rx_hold_req;
  int unsigned rx_stall_left;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    rx_stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_stall_left = LONG_HOLD;
      end
      if (rx_stall_left != 0) begin
        out_ch.ready <= 1'b0;
        rx_stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        // start a stall burst of random length
        rx_stall_left = $urandom_range(0, 11);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every result item that the block hands over.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.check_result('{status: out_ch.status, data: out_ch.out_data,
                             size: out_ch.out_size, fill: out_ch.fill_count,
                             is_empty: out_ch.now_empty, is_full: out_ch.now_full});
    end
  end

  // Watchdog: end a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Offer one operation, hold it until the block takes it, then record it.
  task automatic send_op(input logic [MODE_W-1:0] op, input logic [DATA_W-1:0] word,
                         input logic [SIZE_W-1:0] sz, input logic [POS_W-1:0] at);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= op;
    in_ch.entry_data <= word;
    in_ch.entry_size <= sz;
    in_ch.position   <= at;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    tracker.note_op(op, word, sz, at);
  endtask

  // Drop valid and wait for every outstanding result.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  // Pick one operation biased by phase; positions mostly land near the fill level.
  task automatic send_random_op(input phase_e phase);
    logic [MODE_W-1:0] op;
    logic [SIZE_W-1:0] sz;
    logic [POS_W-1:0]  at;
    int                roll;
    int                ins_pct;
    bit                positional;
    case (phase)
      PH_FILL:  ins_pct = 75;
      PH_DRAIN: ins_pct = 25;
      PH_MIXED: ins_pct = 50;
      default:  ins_pct = 55;
    endcase
    positional = (phase == PH_POSITIONAL) && $urandom_range(0, 3) != 0;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      if (positional) begin
        op = M_INS_AT;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = M_INS_FIRST;
          1:       op = M_INS_LAST;
          default: op = M_INS_AT;
        endcase
      end
    end else if (roll < 99) begin
      if (positional) begin
        op = ($urandom_range(0, 2) == 0) ? M_PEEK_AT : M_EXT_AT;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = M_EXT_FIRST;
          1:       op = M_EXT_LAST;
          2:       op = M_EXT_AT;
          default: op = M_PEEK_AT;
        endcase
      end
    end else begin
      op = M_CLEAR;
    end
    sz = ($urandom_range(0, 24) == 0) ? '0 : SIZE_W'($urandom_range(1, 16'hFFFF));
    if ($urandom_range(0, 15) == 0) at = POS_W'($urandom_range(0, 16'hFFFF));
    else at = POS_W'($urandom_range(0, tracker.count + 1));
    send_op(op, $urandom, sz, at);
  endtask

  initial begin
    phase_e      phase;
    int unsigned phase_left;
    tracker = new();
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold_req = 1'b0;

    // hold every input at a known value from time zero
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= M_CLEAR;
    in_ch.entry_data <= '0;
    in_ch.entry_size <= '0;
    in_ch.position   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every operation, empty and range errors, zero size, inserts at
    // the front, middle and past the end, and extracts from both ends and middle.
    send_op(M_CLEAR,     32'h0,        16'h0,    16'h0);
    send_op(M_EXT_FIRST, 32'h0,        16'h0,    16'h0);
    send_op(M_EXT_LAST,  32'h0,        16'h0,    16'h0);
    send_op(M_EXT_AT,    32'h0,        16'h0,    16'h0);
    send_op(M_PEEK_AT,   32'h0,        16'h0,    16'h0);
    send_op(M_INS_FIRST, 32'hDEADBEEF, 16'h0,    16'h0);
    send_op(M_INS_AT,    32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
    send_op(M_INS_FIRST, 32'h00000000, 16'h0001, 16'h0);
    send_op(M_INS_LAST,  32'h12345678, 16'h8000, 16'h0);
    send_op(M_INS_AT,    32'h0BADF00D, 16'h0010, 16'h0);
    send_op(M_INS_AT,    32'hA5A5A5A5, 16'h5A5A, 16'h0002);
    send_op(M_INS_AT,    32'h5A5A5A5A, 16'hA5A5, 16'h0005);
    send_op(M_PEEK_AT,   32'h0,        16'h0,    16'h0002);
    send_op(M_PEEK_AT,   32'h0,        16'h0,    16'hFFFF);
    send_op(M_PEEK_AT,   32'h0,        16'h0,    16'h0006);
    send_op(M_EXT_AT,    32'h0,        16'h0,    16'h0001);
    send_op(M_EXT_AT,    32'h0,        16'h0,    16'hFFFF);
    send_op(M_EXT_FIRST, 32'h0,        16'h0,    16'h0);
    send_op(M_EXT_LAST,  32'h0,        16'h0,    16'h0);
    send_op(M_INS_LAST,  32'h13579BDF, 16'h0,    16'h0);
    send_op(M_CLEAR,     32'h0,        16'h0,    16'h0);
    send_op(M_EXT_LAST,  32'h0,        16'h0,    16'h0);

    // Random: phases that push toward full, toward empty, or work the middle.
    phase      = PH_FILL;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 3));
        phase_left = $urandom_range(30, 90);
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      // back the block up while the sender keeps offering items
      if (n == 400) rx_hold_req = 1'b1;
      // let the block run dry once mid-run
      if (n == 800) drain_results();
      send_random_op(phase);
      phase_left--;
    end

    drain_results();
    repeat (DEPTH + 10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- ring_deque_with_positional_insert.f -----
+incdir+design
design/rdq_pkg.sv
design/rdq_in_if.sv
design/rdq_out_if.sv
design/rdq_addr.sv
design/rdq_store.sv
design/ring_deque_with_positional_insert.sv
design/rdq_checker.sv
sim/ring_deque_with_positional_insert_tb.sv
